// File: design/maze_line_follow_controller_core_assert.svh
// Assertion macros shared by the controller's checking code.
`ifndef MAZE_LINE_FOLLOW_CONTROLLER_CORE_ASSERT_SVH
`define MAZE_LINE_FOLLOW_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("maze line follow controller: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MLF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("maze line follow controller: next-cycle check failed");

`endif

// File: design/mlf_pkg.sv
// Shared types and constants of the maze line follow controller.
package mlf_pkg;

	typedef enum logic [1:0] {
		ACT_STOP   = 2'd0,
		ACT_DRIVE  = 2'd1,
		ACT_SPIN_L = 2'd2,
		ACT_SPIN_R = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		MODE_RUN   = 2'd0,
		MODE_LEFT  = 2'd1,
		MODE_RIGHT = 2'd2,
		MODE_BACK  = 2'd3
	} mode_t;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_CRUISE_SPEED   = 3'd0;
	localparam logic [2:0] CFG_OBSTACLE_LIMIT = 3'd1;
	localparam logic [2:0] CFG_PIVOT_SPEED    = 3'd2;
	localparam logic [2:0] CFG_GAIN_P         = 3'd3;
	localparam logic [2:0] CFG_GAIN_D         = 3'd4;
	localparam logic [2:0] CFG_QUARTER_TICKS  = 3'd5;
	localparam logic [2:0] CFG_REVERSE_TICKS  = 3'd6;
	localparam logic [2:0] CFG_LIMIT_TICKS    = 3'd7;

	localparam logic [4:0] JUNCTION_ALL = 5'h0F;
	localparam logic [5:0] SONAR_PERIOD = 6'd60;
	localparam logic [10:0] ELAPSED_MAX = 11'd2047;
	localparam logic signed [18:0] PD_LIMIT = 19'sd300;
	localparam logic signed [11:0] SPEED_MAX = 12'sd1000;
	localparam logic [9:0] SPEED_MAX_U = 10'd1000;

	typedef struct packed {
		logic [9:0] cruise_speed;
		logic [9:0] obstacle_limit;
		logic [9:0] pivot_speed;
		logic [7:0] gain_p;
		logic [7:0] gain_d;
		logic [9:0] quarter_turn_ticks;
		logic [9:0] reverse_turn_ticks;
		logic [9:0] turn_limit_ticks;
	} cfg_t;

	// decision handed from the mode logic to the speed logic
	typedef struct packed {
		act_t              act;
		logic              trig;
		logic signed [7:0] err;
		logic signed [8:0] diff;
	} dec_t;

	typedef struct packed {
		act_t       act;
		logic [9:0] left_speed;
		logic [9:0] right_speed;
		logic       trig;
	} res_t;

endpackage

// File: design/maze_line_follow_controller_core.sv
// A request passes the input, decision, product and output registers before it
// shows on m_tdata. Throughput: one request per cycle while the output is free or
// taken; the input, decision, product and output registers all advance together.
// Reset: arst_n clears valid flags, run mode, counters, last error and restores
// the configuration registers to their defaults.
`include "maze_line_follow_controller_core_assert.svh"

// Top level of the maze line follow controller.
module maze_line_follow_controller_core import mlf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // line_bits[7:0], front_distance[17:8], line_error[25:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // motor_action[1:0], left_speed[11:2],
	                               // right_speed[21:12], sonar_trigger[22]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	cfg_t cfg_q;

	logic              en;
	logic              v_s1, v_s2, v_s3;
	logic [7:0]        line_bits_s1;
	logic [9:0]        front_s1;
	logic signed [7:0] err_s1;
	dec_t              dec_s2;
	res_t              res;
	logic              out_valid_q;
	res_t              out_q;

	// advance the whole pipe when the output is free or taken
	assign en        = !out_valid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cruise_speed       <= 10'd500;
			cfg_q.obstacle_limit     <= 10'd10;
			cfg_q.pivot_speed        <= 10'd450;
			cfg_q.gain_p             <= 8'd35;
			cfg_q.gain_d             <= 8'd15;
			cfg_q.quarter_turn_ticks <= 10'd180;
			cfg_q.reverse_turn_ticks <= 10'd350;
			cfg_q.turn_limit_ticks   <= 10'd600;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CRUISE_SPEED:   cfg_q.cruise_speed       <= cfg_data;
				CFG_OBSTACLE_LIMIT: cfg_q.obstacle_limit     <= cfg_data;
				CFG_PIVOT_SPEED:    cfg_q.pivot_speed        <= cfg_data;
				CFG_GAIN_P:         cfg_q.gain_p             <= cfg_data[7:0];
				CFG_GAIN_D:         cfg_q.gain_d             <= cfg_data[7:0];
				CFG_QUARTER_TICKS:  cfg_q.quarter_turn_ticks <= cfg_data;
				CFG_REVERSE_TICKS:  cfg_q.reverse_turn_ticks <= cfg_data;
				CFG_LIMIT_TICKS:    cfg_q.turn_limit_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid flags of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// input register and result register
	always_ff @(posedge clk) begin
		if (en) begin
			line_bits_s1 <= s_tdata[7:0];
			front_s1     <= s_tdata[17:8];
			err_s1       <= s_tdata[25:18];
			out_q        <= res;
		end
	end

	mlf_decide u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.fire           (en && v_s1),
		.cfg            (cfg_q),
		.line_bits      (line_bits_s1),
		.front_distance (front_s1),
		.line_error     (err_s1),
		.dec_s2         (dec_s2)
	);

	mlf_pd u_pd (
		.clk    (clk),
		.en     (en),
		.cfg    (cfg_q),
		.dec_s2 (dec_s2),
		.res    (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.trig, out_q.right_speed, out_q.left_speed, out_q.act};

	// a stopped result drives both wheels at zero
	`MLF_ASSERT_NOW(a_stop_zero, m_tvalid && (m_tdata[1:0] == ACT_STOP), m_tdata[21:2] == 20'd0)
	// a spin drives both wheels at the same speed
	`MLF_ASSERT_NOW(a_spin_equal,
		m_tvalid && ((m_tdata[1:0] == ACT_SPIN_L) || (m_tdata[1:0] == ACT_SPIN_R)),
		m_tdata[11:2] == m_tdata[21:12])
	// a product stage item reaches the output on the next advance
	`MLF_ASSERT_NEXT(a_pipe_move, en && v_s3, out_valid_q)

endmodule

// File: design/mlf_decide.sv
// Mode state machine, sonar timing and action choice per tick.
module mlf_decide import mlf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              fire,
	input  cfg_t              cfg,
	input  logic [7:0]        line_bits,
	input  logic [9:0]        front_distance,
	input  logic signed [7:0] line_error,
	output dec_t              dec_s2
);

	mode_t             mode_q, mode_d;
	logic [10:0]       elapsed_q, elapsed_d;
	logic signed [7:0] last_err_q, last_err_d;
	logic [5:0]        sonar_q, sonar_d;

	logic [5:0]  sonar_inc;
	logic        trig;
	logic [9:0]  need;
	logic        turn_done;
	logic        obstacle;
	logic        jl, jr, jall;
	mode_t       pick;
	dec_t        dec_d;

	// classify the tick
	always_comb begin
		sonar_inc = (sonar_q < SONAR_PERIOD) ? sonar_q + 6'd1 : sonar_q;
		trig      = (mode_q == MODE_RUN) && (sonar_inc >= SONAR_PERIOD);
		need      = (mode_q == MODE_BACK) ? cfg.reverse_turn_ticks : cfg.quarter_turn_ticks;
		turn_done = (elapsed_q >= {1'b0, need}) &&
			((line_bits != 8'd0) || (elapsed_q > {1'b0, cfg.turn_limit_ticks}));
		obstacle  = (front_distance != 10'd0) && (front_distance < cfg.obstacle_limit);
		jl        = (line_bits[1:0] == 2'b11);
		jr        = (line_bits[4:3] == 2'b11);
		jall      = (line_bits[4:0] >= JUNCTION_ALL);
		if (obstacle) begin
			pick = jl ? MODE_LEFT : (jr ? MODE_RIGHT : MODE_BACK);
		end else if (jall || jl) begin
			pick = MODE_LEFT;
		end else if (jr) begin
			pick = MODE_RIGHT;
		end else begin
			pick = MODE_RUN;
		end
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		elapsed_d  = elapsed_q;
		last_err_d = last_err_q;
		sonar_d    = sonar_inc;
		case (mode_q)
			MODE_RUN: begin
				if (trig) begin
					sonar_d = 6'd0;
				end
				mode_d = pick;
				if (pick != MODE_RUN) begin
					elapsed_d = 11'd1;
				end else if (line_bits != 8'd0) begin
					last_err_d = line_error;
				end
			end
			default: begin
				if (turn_done) begin
					mode_d    = MODE_RUN;
					elapsed_d = 11'd0;
				end else if (elapsed_q < ELAPSED_MAX) begin
					elapsed_d = elapsed_q + 11'd1;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		dec_d.trig = trig;
		dec_d.err  = line_error;
		dec_d.diff = $signed({line_error[7], line_error}) - $signed({last_err_q[7], last_err_q});
		case (mode_q)
			MODE_RUN: begin
				case (pick)
					MODE_LEFT:  dec_d.act = ACT_SPIN_L;
					MODE_RIGHT: dec_d.act = ACT_SPIN_R;
					MODE_BACK:  dec_d.act = ACT_SPIN_R;
					default:    dec_d.act = (line_bits == 8'd0) ? ACT_STOP : ACT_DRIVE;
				endcase
			end
			MODE_LEFT: dec_d.act = ACT_SPIN_L;
			default:   dec_d.act = ACT_SPIN_R;
		endcase
	end

	// advance state on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RUN;
			elapsed_q  <= 11'd0;
			last_err_q <= 8'sd0;
			sonar_q    <= 6'd0;
		end else if (fire) begin
			mode_q     <= mode_d;
			elapsed_q  <= elapsed_d;
			last_err_q <= last_err_d;
			sonar_q    <= sonar_d;
		end
	end

	// hold the decision for the speed stage
	always_ff @(posedge clk) begin
		if (en) begin
			dec_s2 <= dec_d;
		end
	end

endmodule

// File: design/mlf_pd.sv
// PD steering law and wheel speed selection.
module mlf_pd import mlf_pkg::*; (
	input  logic clk,
	input  logic en,
	input  cfg_t cfg,
	input  dec_t dec_s2,
	output res_t res
);

	act_t               act_s3;
	logic               trig_s3;
	logic signed [16:0] prod_p_s3;
	logic signed [17:0] prod_d_s3;

	logic signed [18:0] sum;
	logic signed [9:0]  p;
	logic signed [11:0] p_ext;
	logic signed [11:0] base_ext;
	logic signed [11:0] lsum, rsum;
	logic [9:0]         lspd, rspd, spin;

	// register the two gain products
	always_ff @(posedge clk) begin
		if (en) begin
			act_s3    <= dec_s2.act;
			trig_s3   <= dec_s2.trig;
			prod_p_s3 <= $signed({9'd0, cfg.gain_p}) *
				$signed({{9{dec_s2.err[7]}}, dec_s2.err});
			prod_d_s3 <= $signed({10'd0, cfg.gain_d}) *
				$signed({{9{dec_s2.diff[8]}}, dec_s2.diff});
		end
	end

	// sum, clamp and derive wheel speeds
	always_comb begin
		sum = $signed({{2{prod_p_s3[16]}}, prod_p_s3}) + $signed({prod_d_s3[17], prod_d_s3});
		if (sum > PD_LIMIT) begin
			p = 10'sd300;
		end else if (sum < -PD_LIMIT) begin
			p = -10'sd300;
		end else begin
			p = sum[9:0];
		end
		p_ext    = {{2{p[9]}}, p};
		base_ext = $signed({2'b00, cfg.cruise_speed});
		lsum     = base_ext - p_ext;
		rsum     = base_ext + p_ext;
		if (lsum[11]) begin
			lspd = 10'd0;
		end else if (lsum > SPEED_MAX) begin
			lspd = SPEED_MAX_U;
		end else begin
			lspd = lsum[9:0];
		end
		if (rsum[11]) begin
			rspd = 10'd0;
		end else if (rsum > SPEED_MAX) begin
			rspd = SPEED_MAX_U;
		end else begin
			rspd = rsum[9:0];
		end
		spin = (cfg.pivot_speed > SPEED_MAX_U) ? SPEED_MAX_U : cfg.pivot_speed;
	end

	// select speeds by action
	always_comb begin
		res.act  = act_s3;
		res.trig = trig_s3;
		case (act_s3)
			ACT_STOP: begin
				res.left_speed  = 10'd0;
				res.right_speed = 10'd0;
			end
			ACT_DRIVE: begin
				res.left_speed  = lspd;
				res.right_speed = rspd;
			end
			default: begin
				res.left_speed  = spin;
				res.right_speed = spin;
			end
		endcase
	end

endmodule
